@@ design/gpio_edge_detect_registers_assert.svh @@
// Assertion macros used by the checker file of the GPIO edge detect block.
`ifndef GPIO_EDGE_DETECT_REGISTERS_ASSERT_SVH
`define GPIO_EDGE_DETECT_REGISTERS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GEDR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gedr assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GEDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gedr assertion failed");

`endif

@@ design/gedr_pkg.sv @@
// Types, codes and constants of the GPIO edge detect register block.
`timescale 1ns / 1ps

package gedr_pkg;

  // Number of pins handled by the block.
  localparam int unsigned PinCount = 28;
  // Edge status bits that drive an interrupt source of their own.
  localparam int unsigned LowIrqBits = 11;
  localparam int unsigned IrqWidth = LowIrqBits + 1;
  localparam int unsigned DataWidth = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InTdataWidth = 48;
  localparam int unsigned OutTdataWidth = 104;
  localparam int unsigned FuncWidth = 3;

  // Highest valid register word offset.
  localparam logic [7:0] LastRegOffset = 8'h1C;

  typedef logic [PinCount-1:0] pins_t;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_READ_WORD  = 3'd0,
    FUNC_WRITE_WORD = 3'd1,
    FUNC_READ_BYTE  = 3'd2,
    FUNC_WRITE_BYTE = 3'd3,
    FUNC_PIN_CHANGE = 3'd4
  } func_t;

  // Register index, byte offset divided by four.
  typedef enum logic [2:0] {
    REG_LEVEL  = 3'd0,
    REG_DIR    = 3'd1,
    REG_SET    = 3'd2,
    REG_CLEAR  = 3'd3,
    REG_RISE   = 3'd4,
    REG_FALL   = 3'd5,
    REG_STATUS = 3'd6,
    REG_ALT    = 3'd7
  } reg_idx_t;

  // One accepted input item.
  typedef struct packed {
    logic [FuncWidth-1:0] func;
    logic [7:0]           offset;
    logic [DataWidth-1:0] write_data;
    logic [4:0]           pin;
    logic                 level;
  } item_t;

endpackage

@@ design/gpio_edge_detect_registers.sv @@
// Top level of the 28-pin GPIO register block with edge detection.
`timescale 1ns / 1ps

// GPIO register block: each input item is a word or byte register read, a word
// or byte register write, or a change of one input pin, and each gives exactly
// one result item with read data, an access error flag, twelve interrupt source
// levels, the output latch and the pin directions as they stand after that
// item. An item passes through the input register, then through the register
// decode and update logic into the result register. One item is accepted per
// cycle while the result side is not stalled; the input register lets one more
// item in while a result waits to be taken. Registers sit at byte offsets
// 0x00 level, 0x04 direction, 0x08 set, 0x0C clear, 0x10 rise enable,
// 0x14 fall enable, 0x18 edge status (write one to clear), 0x1C alternate
// function. Reset clears all registers.
module gpio_edge_detect_registers (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input items
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: offset[7:0], write_data[31:0], pin[4:0], level, zero pad
  input  logic [gedr_pkg::InTdataWidth-1:0]    s_axis_tdata,
  // tuser: func[2:0]
  input  logic [gedr_pkg::FuncWidth-1:0]       s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata from bit 0: read_data[31:0], access_error, irq_sources[11:0],
  // pin_outputs[27:0], pin_directions[27:0], zero pad
  output logic [gedr_pkg::OutTdataWidth-1:0]   m_axis_tdata
);

  localparam int unsigned P = gedr_pkg::PinCount;
  localparam int unsigned OutUsed = gedr_pkg::DataWidth + 1 + gedr_pkg::IrqWidth + 2 * P;

  // Input register
  logic            item_valid;
  gedr_pkg::item_t item;
  logic            advance;

  // Register file
  gedr_pkg::pins_t input_levels, input_levels_next;
  gedr_pkg::pins_t output_latch, output_latch_next;
  gedr_pkg::pins_t direction, direction_next;
  gedr_pkg::pins_t rise_enable, rise_enable_next;
  gedr_pkg::pins_t fall_enable, fall_enable_next;
  gedr_pkg::pins_t edge_status, edge_status_next;
  gedr_pkg::pins_t alt_function, alt_function_next;

  // Decode
  gedr_pkg::reg_idx_t            reg_idx;
  logic                          is_word, is_byte, word_ok, byte_ok;
  logic [4:0]                    lane_shift;
  gedr_pkg::pins_t               read_pins;
  logic [gedr_pkg::DataWidth-1:0] read_word, merge_word, write_word;
  logic                          do_write;
  gedr_pkg::pins_t               write_pins;
  gedr_pkg::pins_t               pin_bit;
  logic                          pin_ok, edge_hit;

  // Results
  logic [gedr_pkg::DataWidth-1:0] read_data_next;
  logic                           access_error_next;
  logic [gedr_pkg::IrqWidth-1:0]  irq_next;
  logic [gedr_pkg::DataWidth-1:0] read_data;
  logic                           access_error;
  logic [gedr_pkg::IrqWidth-1:0]  irq_sources;
  gedr_pkg::pins_t                pin_outputs, pin_directions;

  // Handshake: the item moves on when the result register is free or drains
  assign advance       = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.func       <= s_axis_tuser;
      item.offset     <= s_axis_tdata[7:0];
      item.write_data <= s_axis_tdata[39:8];
      item.pin        <= s_axis_tdata[44:40];
      item.level      <= s_axis_tdata[45];
    end
  end

  // Decode the address
  assign reg_idx    = gedr_pkg::reg_idx_t'(item.offset[4:2]);
  assign is_word    = (item.func == gedr_pkg::FUNC_READ_WORD) ||
                      (item.func == gedr_pkg::FUNC_WRITE_WORD);
  assign is_byte    = (item.func == gedr_pkg::FUNC_READ_BYTE) ||
                      (item.func == gedr_pkg::FUNC_WRITE_BYTE);
  assign byte_ok    = (item.offset & 8'hFC) <= gedr_pkg::LastRegOffset;
  assign word_ok    = byte_ok && (item.offset[1:0] == 2'b00);
  assign lane_shift = {item.offset[1:0], 3'b000};

  // Read the addressed register
  always_comb begin
    unique case (reg_idx)
      gedr_pkg::REG_LEVEL:  read_pins = (output_latch & direction) |
                                        (input_levels & ~direction);
      gedr_pkg::REG_DIR:    read_pins = direction;
      gedr_pkg::REG_SET:    read_pins = '0;
      gedr_pkg::REG_CLEAR:  read_pins = '0;
      gedr_pkg::REG_RISE:   read_pins = rise_enable;
      gedr_pkg::REG_FALL:   read_pins = fall_enable;
      gedr_pkg::REG_STATUS: read_pins = edge_status;
      gedr_pkg::REG_ALT:    read_pins = alt_function;
      default:              read_pins = '0;
    endcase
  end
  assign read_word = gedr_pkg::DataWidth'(read_pins);

  // Build the write value; a byte write to the status register clears only that byte
  assign merge_word = (reg_idx == gedr_pkg::REG_STATUS) ? '0 :
                      (read_word & ~(32'h0000_00FF << lane_shift));
  assign write_word = is_word ? item.write_data :
                      (merge_word | (gedr_pkg::DataWidth'(item.write_data[7:0]) << lane_shift));
  assign write_pins = write_word[P-1:0];
  assign do_write   = ((item.func == gedr_pkg::FUNC_WRITE_WORD) && word_ok) ||
                      ((item.func == gedr_pkg::FUNC_WRITE_BYTE) && byte_ok);

  // Pin change decode
  assign pin_ok   = 32'(item.pin) < P;
  assign pin_bit  = gedr_pkg::pins_t'(1) << item.pin;
  assign edge_hit = item.level ? |(rise_enable & pin_bit) : |(fall_enable & pin_bit);

  // Next register values
  always_comb begin
    input_levels_next = input_levels;
    output_latch_next = output_latch;
    direction_next    = direction;
    rise_enable_next  = rise_enable;
    fall_enable_next  = fall_enable;
    edge_status_next  = edge_status;
    alt_function_next = alt_function;
    if (do_write) begin
      unique case (reg_idx)
        gedr_pkg::REG_LEVEL:  ;
        gedr_pkg::REG_DIR:    direction_next = write_pins;
        gedr_pkg::REG_SET:    output_latch_next = output_latch | (write_pins & direction);
        gedr_pkg::REG_CLEAR:  output_latch_next = output_latch & ~(write_pins & direction);
        gedr_pkg::REG_RISE:   rise_enable_next = write_pins;
        gedr_pkg::REG_FALL:   fall_enable_next = write_pins;
        gedr_pkg::REG_STATUS: edge_status_next = edge_status & ~write_pins;
        gedr_pkg::REG_ALT:    alt_function_next = write_pins;
        default:              ;
      endcase
    end else if ((item.func == gedr_pkg::FUNC_PIN_CHANGE) && pin_ok) begin
      input_levels_next = item.level ? (input_levels | pin_bit) : (input_levels & ~pin_bit);
      // Latch status only on a real level change that the enables select
      if ((input_levels_next != input_levels) && edge_hit) begin
        edge_status_next = edge_status | pin_bit;
      end
    end
  end

  // Result fields
  always_comb begin
    read_data_next    = '0;
    access_error_next = 1'b0;
    if (is_word && !word_ok) begin
      access_error_next = 1'b1;
    end else if (is_byte && !byte_ok) begin
      access_error_next = 1'b1;
    end else if (item.func == gedr_pkg::FUNC_READ_WORD) begin
      read_data_next = read_word;
    end else if (item.func == gedr_pkg::FUNC_READ_BYTE) begin
      read_data_next = (read_word >> lane_shift) & 32'h0000_00FF;
    end
  end
  assign irq_next = {|edge_status_next[P-1:gedr_pkg::LowIrqBits],
                     edge_status_next[gedr_pkg::LowIrqBits-1:0]};

  // Update the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      input_levels <= '0;
      output_latch <= '0;
      direction    <= '0;
      rise_enable  <= '0;
      fall_enable  <= '0;
      edge_status  <= '0;
      alt_function <= '0;
    end else if (advance) begin
      input_levels <= input_levels_next;
      output_latch <= output_latch_next;
      direction    <= direction_next;
      rise_enable  <= rise_enable_next;
      fall_enable  <= fall_enable_next;
      edge_status  <= edge_status_next;
      alt_function <= alt_function_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data      <= read_data_next;
      access_error   <= access_error_next;
      irq_sources    <= irq_next;
      pin_outputs    <= output_latch_next;
      pin_directions <= direction_next;
    end
  end

  assign m_axis_tdata = {(gedr_pkg::OutTdataWidth - OutUsed)'(0),
                         pin_directions, pin_outputs, irq_sources,
                         access_error, read_data};

endmodule

@@ design/gedr_checker.sv @@
// Port-level checker of the GPIO edge detect register block, and its bind.
`timescale 1ns / 1ps
`include "gpio_edge_detect_registers_assert.svh"

module gedr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [gedr_pkg::OutTdataWidth-1:0]  m_axis_tdata
);

  // A stalled result holds
  `GEDR_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

  // Input backpressure only comes from a stalled, full result side
  `GEDR_ASSERT_SAME(a_ready_only_on_stall, !s_axis_tready,
                    m_axis_tvalid && !m_axis_tready)

  // A failed access returns no read data
  `GEDR_ASSERT_SAME(a_error_no_data, m_axis_tvalid && m_axis_tdata[32],
                    m_axis_tdata[31:0] == 32'h0)

endmodule

bind gpio_edge_detect_registers gedr_checker u_gedr_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking stream testbench for the GPIO edge detect register block.
`timescale 1ns / 1ps

module tb_top;

  // Func codes the block decodes as no operation
  localparam logic [gedr_pkg::FuncWidth-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [gedr_pkg::FuncWidth-1:0] FUNC_SPARE_LAST  = 3'd7;

  localparam int unsigned RandomItems   = 1150;
  localparam int unsigned CalmItems     = 150;
  localparam int unsigned HoldoffAt     = 300;
  localparam int unsigned HoldoffCycles = 120;
  localparam int unsigned DrainAt       = 700;
  localparam int unsigned TailCycles    = 10;

  localparam gedr_pkg::pins_t AllPins = '1;

  // Result fields, MSB first, laid out as in m_axis_tdata
  typedef struct packed {
    gedr_pkg::pins_t                pin_directions;
    gedr_pkg::pins_t                pin_outputs;
    logic [gedr_pkg::IrqWidth-1:0]  irq_sources;
    logic                           access_error;
    logic [gedr_pkg::DataWidth-1:0] read_data;
  } gpio_result_t;

  typedef struct {
    gedr_pkg::item_t req;
    bit              typed;
    gpio_result_t    want;
  } stim_row_t;

  localparam gpio_result_t ResultClean = '0;
  localparam gpio_result_t ResultError = {gedr_pkg::pins_t'(0), gedr_pkg::pins_t'(0),
                                          gedr_pkg::IrqWidth'(0), 1'b1,
                                          gedr_pkg::DataWidth'(0)};

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [gedr_pkg::InTdataWidth-1:0]  s_axis_tdata = '0;
  logic [gedr_pkg::FuncWidth-1:0]     s_axis_tuser = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [gedr_pkg::OutTdataWidth-1:0] m_axis_tdata;

  // Shadow copy of the block's registers
  gedr_pkg::pins_t sh_levels = '0;
  gedr_pkg::pins_t sh_latch  = '0;
  gedr_pkg::pins_t sh_dir    = '0;
  gedr_pkg::pins_t sh_rise   = '0;
  gedr_pkg::pins_t sh_fall   = '0;
  gedr_pkg::pins_t sh_status = '0;
  gedr_pkg::pins_t sh_alt    = '0;

  gpio_result_t pending_results[$];
  int unsigned  sent_count = 0;
  int unsigned  mismatch_count = 0;
  bit           calm_phase = 1'b0;

  gpio_edge_detect_registers dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] reg_off(gedr_pkg::reg_idx_t idx, logic [1:0] lane);
    return {3'b000, idx, lane};
  endfunction

  // Register read as the bus sees it; write-only registers read as zero
  function automatic logic [gedr_pkg::DataWidth-1:0] shadow_read(gedr_pkg::reg_idx_t idx);
    case (idx)
      gedr_pkg::REG_LEVEL:
        return gedr_pkg::DataWidth'((sh_latch & sh_dir) | (sh_levels & ~sh_dir));
      gedr_pkg::REG_DIR:    return gedr_pkg::DataWidth'(sh_dir);
      gedr_pkg::REG_RISE:   return gedr_pkg::DataWidth'(sh_rise);
      gedr_pkg::REG_FALL:   return gedr_pkg::DataWidth'(sh_fall);
      gedr_pkg::REG_STATUS: return gedr_pkg::DataWidth'(sh_status);
      gedr_pkg::REG_ALT:    return gedr_pkg::DataWidth'(sh_alt);
      default:              return '0;
    endcase
  endfunction

  function automatic void shadow_write(gedr_pkg::reg_idx_t idx,
                                       logic [gedr_pkg::DataWidth-1:0] value);
    gedr_pkg::pins_t v;
    v = value[gedr_pkg::PinCount-1:0];
    case (idx)
      gedr_pkg::REG_DIR:    sh_dir = v;
      gedr_pkg::REG_SET:    sh_latch = sh_latch | (v & sh_dir);
      gedr_pkg::REG_CLEAR:  sh_latch = sh_latch & ~(v & sh_dir);
      gedr_pkg::REG_RISE:   sh_rise = v;
      gedr_pkg::REG_FALL:   sh_fall = v;
      gedr_pkg::REG_STATUS: sh_status = sh_status & ~v;
      gedr_pkg::REG_ALT:    sh_alt = v;
      default:              ;
    endcase
  endfunction

  // Apply one item to the shadow registers and return the result it gives
  function automatic gpio_result_t gpio_predict(gedr_pkg::item_t it);
    gpio_result_t                   res;
    gedr_pkg::reg_idx_t             idx;
    logic [4:0]                     shift;
    logic [gedr_pkg::DataWidth-1:0] byte_val;
    logic [gedr_pkg::DataWidth-1:0] cur;
    gedr_pkg::pins_t                bit_mask;
    gedr_pkg::pins_t                prev;
    res = '0;
    idx = gedr_pkg::reg_idx_t'(it.offset[4:2]);
    shift = {it.offset[1:0], 3'b000};
    byte_val = gedr_pkg::DataWidth'(it.write_data[7:0]);
    case (it.func)
      gedr_pkg::FUNC_READ_WORD, gedr_pkg::FUNC_WRITE_WORD: begin
        if (it.offset > gedr_pkg::LastRegOffset || it.offset[1:0] != 2'b00) begin
          res.access_error = 1'b1;
        end else if (it.func == gedr_pkg::FUNC_READ_WORD) begin
          res.read_data = shadow_read(idx);
        end else begin
          shadow_write(idx, it.write_data);
        end
      end
      gedr_pkg::FUNC_READ_BYTE, gedr_pkg::FUNC_WRITE_BYTE: begin
        if ({it.offset[7:2], 2'b00} > gedr_pkg::LastRegOffset) begin
          res.access_error = 1'b1;
        end else if (it.func == gedr_pkg::FUNC_READ_BYTE) begin
          res.read_data = gedr_pkg::DataWidth'(8'(shadow_read(idx) >> shift));
        end else if (idx == gedr_pkg::REG_STATUS) begin
          // clear only the ones in the written byte
          sh_status = sh_status & ~gedr_pkg::pins_t'(byte_val << shift);
        end else begin
          cur = shadow_read(idx) & ~(gedr_pkg::DataWidth'(8'hFF) << shift);
          shadow_write(idx, cur | (byte_val << shift));
        end
      end
      gedr_pkg::FUNC_PIN_CHANGE: begin
        if (it.pin < gedr_pkg::PinCount) begin
          bit_mask = gedr_pkg::pins_t'(1) << it.pin;
          prev = sh_levels;
          sh_levels = it.level ? (sh_levels | bit_mask) : (sh_levels & ~bit_mask);
          if (prev != sh_levels &&
              ((it.level && |(sh_rise & bit_mask)) || (!it.level && |(sh_fall & bit_mask))))
            sh_status = sh_status | bit_mask;
        end
      end
      default: ;
    endcase
    res.irq_sources = {|sh_status[gedr_pkg::PinCount-1:gedr_pkg::LowIrqBits],
                       sh_status[gedr_pkg::LowIrqBits-1:0]};
    res.pin_outputs = sh_latch;
    res.pin_directions = sh_dir;
    return res;
  endfunction

  function automatic stim_row_t make_row(logic [gedr_pkg::FuncWidth-1:0] func,
                                         logic [7:0] offset,
                                         logic [gedr_pkg::DataWidth-1:0] data,
                                         logic [4:0] pin, logic level, bit typed = 1'b0,
                                         gpio_result_t want = '0);
    stim_row_t row;
    row.req.func = func;
    row.req.offset = offset;
    row.req.write_data = data;
    row.req.pin = pin;
    row.req.level = level;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // Mostly well-formed register traffic and pin toggles, with some noise
  function automatic gedr_pkg::item_t rand_item();
    gedr_pkg::item_t it;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    it.offset = ($urandom_range(0, 7) == 0) ?
                8'($urandom_range(0, 255)) :
                reg_off(gedr_pkg::reg_idx_t'($urandom_range(0, 7)), 2'b00);
    case ($urandom_range(0, 3))
      0:       it.write_data = '1;
      1:       it.write_data = gedr_pkg::DataWidth'(1) <<
                               $urandom_range(0, gedr_pkg::DataWidth - 1);
      default: it.write_data = $urandom;
    endcase
    it.pin = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, gedr_pkg::PinCount - 1));
    it.level = 1'($urandom_range(0, 1));
    if (pick < 35) begin
      it.func = gedr_pkg::FUNC_PIN_CHANGE;
    end else if (pick < 55) begin
      it.func = gedr_pkg::FUNC_WRITE_WORD;
    end else if (pick < 68) begin
      it.func = gedr_pkg::FUNC_READ_WORD;
    end else if (pick < 80) begin
      it.func = gedr_pkg::FUNC_READ_BYTE;
      it.offset[1:0] = 2'($urandom_range(0, 3));
    end else if (pick < 92) begin
      it.func = gedr_pkg::FUNC_WRITE_BYTE;
      it.offset[1:0] = 2'($urandom_range(0, 3));
    end else if (pick < 96) begin
      it.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    end else begin
      it.func = 3'($urandom_range(0, 7));
      it.offset = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // Offer one item and hold it until taken; tvalid stays high afterwards
  task automatic push_item(gedr_pkg::item_t it, bit typed, gpio_result_t want);
    gpio_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= gedr_pkg::InTdataWidth'({it.level, it.pin, it.write_data, it.offset});
    do @(posedge clk); while (!s_axis_tready);
    predicted = gpio_predict(it);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [gedr_pkg::DataWidth-1:0] want,
                             logic [gedr_pkg::DataWidth-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    gpio_result_t got;
    gpio_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = gpio_result_t'(m_axis_tdata[$bits(gpio_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("access_error", gedr_pkg::DataWidth'(want.access_error),
                    gedr_pkg::DataWidth'(got.access_error));
        check_field("irq_sources", gedr_pkg::DataWidth'(want.irq_sources),
                    gedr_pkg::DataWidth'(got.irq_sources));
        check_field("pin_outputs", gedr_pkg::DataWidth'(want.pin_outputs),
                    gedr_pkg::DataWidth'(got.pin_outputs));
        check_field("pin_directions", gedr_pkg::DataWidth'(want.pin_directions),
                    gedr_pkg::DataWidth'(got.pin_directions));
      end
    end
  end

  // Receiver: random stalls, one long hold-off, none near the end
  initial begin : result_sink
    bit held_off;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && sent_count >= HoldoffAt) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows[$];
    // error cases and reset values
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_WORD,
                                     reg_off(gedr_pkg::REG_LEVEL, 2'b00), '0, '0, 1'b0,
                                     1'b1, ResultClean));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_WORD, 8'h20, '0, '0, 1'b0, 1'b1,
                                     ResultError));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD, 8'hFF, '1, '0, 1'b0, 1'b1,
                                     ResultError));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_DIR, 2'b10), '1, '0, 1'b0,
                                     1'b1, ResultError));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_BYTE, 8'hFF, '0, '0, 1'b0, 1'b1,
                                     ResultError));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_BYTE, 8'h20, '1, '0, 1'b0, 1'b1,
                                     ResultError));
    // all pins to output, all driven high
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_DIR, 2'b00), '1, '0, 1'b0,
                                     1'b1, {AllPins, gedr_pkg::pins_t'(0),
                                            gedr_pkg::IrqWidth'(0), 1'b0,
                                            gedr_pkg::DataWidth'(0)}));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_SET, 2'b00), '1, '0, 1'b0,
                                     1'b1, {AllPins, AllPins, gedr_pkg::IrqWidth'(0), 1'b0,
                                            gedr_pkg::DataWidth'(0)}));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_WORD,
                                     reg_off(gedr_pkg::REG_LEVEL, 2'b00), '0, '0, 1'b0,
                                     1'b1, {AllPins, AllPins, gedr_pkg::IrqWidth'(0), 1'b0,
                                            gedr_pkg::DataWidth'(AllPins)}));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_WORD,
                                     reg_off(gedr_pkg::REG_SET, 2'b00), '0, '0, 1'b0,
                                     1'b1, {AllPins, AllPins, gedr_pkg::IrqWidth'(0), 1'b0,
                                            gedr_pkg::DataWidth'(0)}));
    // byte clear, ignored level write, edge enables
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_BYTE,
                                     reg_off(gedr_pkg::REG_CLEAR, 2'b01), 32'h5A, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_LEVEL, 2'b00), '0, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_RISE, 2'b00), '1, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_BYTE,
                                     reg_off(gedr_pkg::REG_FALL, 2'b11), 32'hFF, '0, 1'b0));
    // edges on output pins, repeated level, pin out of range, spare func codes
    directed_rows.push_back(make_row(gedr_pkg::FUNC_PIN_CHANGE, '0, '0, 5'd0, 1'b1));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_PIN_CHANGE, '0, '0, 5'd27, 1'b1));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_PIN_CHANGE, '0, '0, 5'd27, 1'b1));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_PIN_CHANGE, '0, '0, 5'd31, 1'b1));
    directed_rows.push_back(make_row(FUNC_SPARE_FIRST, 8'h04, '1, 5'd3, 1'b1));
    directed_rows.push_back(make_row(FUNC_SPARE_LAST, 8'hFF, '1, 5'd31, 1'b1));
    // status byte read, byte clear of the top byte only, alternate function write and byte read
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_BYTE,
                                     reg_off(gedr_pkg::REG_STATUS, 2'b11), '0, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_BYTE,
                                     reg_off(gedr_pkg::REG_STATUS, 2'b11), 32'hFF, '0,
                                     1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_ALT, 2'b00), '1, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_READ_BYTE,
                                     reg_off(gedr_pkg::REG_ALT, 2'b11), '0, '0, 1'b0));
    // back to inputs: clear has no effect, falling edge on pin 27, status clear
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_DIR, 2'b00), '0, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_CLEAR, 2'b00), '1, '0, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_PIN_CHANGE, '0, '0, 5'd27, 1'b0));
    directed_rows.push_back(make_row(gedr_pkg::FUNC_WRITE_WORD,
                                     reg_off(gedr_pkg::REG_STATUS, 2'b00), '1, '0, 1'b0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i])
      push_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // random traffic with sender gaps, one full drain, calm tail
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - CalmItems)
        calm_phase = 1'b1;
      if (n == DrainAt) begin
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        idle_sender($urandom_range(1, 15));
      end
      push_item(rand_item(), 1'b0, ResultClean);
    end

    // drain remaining results
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
